// ===== rtl/pwar_pkg.sv =====
// Shared widths, constants and types for the pulse-width average ranger.
package pwar_pkg;

  // Field and register widths
  localparam int unsigned WIDTH_US    = 16;
  localparam int unsigned DIST_W      = 17;
  localparam int unsigned ACC_BITS    = 18;
  localparam int unsigned COUNT_W_DEF = 16;

  // Averaging window; must be a power of two
  localparam int unsigned AVG_LEN   = 4;
  localparam int unsigned AVG_SHIFT = $clog2(AVG_LEN);

  // Count rounding step (power of two)
  localparam int unsigned ROUND_STEP  = 4;
  localparam int unsigned ROUND_SHIFT = $clog2(ROUND_STEP);

  // Distance scale: (d * DIST_MUL + DIST_DIV/2) / DIST_DIV
  localparam int unsigned DIST_MUL   = 3;
  localparam int unsigned DIST_DIV   = 4;
  localparam int unsigned DIST_SHIFT = $clog2(DIST_DIV);

  // Configuration register indexes and reset values
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_NO_TARGET_LIMIT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_ZERO_OFFSET     = 1'b1;
  localparam logic [WIDTH_US-1:0]  LIMIT_RST  = 16'd1990;
  localparam logic [WIDTH_US-1:0]  OFFSET_RST = 16'd1000;
  localparam logic [WIDTH_US-1:0]  LAST_AVG_RST = '1;

  // Pending pulse event from the front end to the result stage
  typedef struct packed {
    logic                valid;
    logic [ACC_BITS-1:0] acc;
  } pwar_evt_t;

endpackage

// ===== rtl/pwar_front.sv =====
// Front end: high-tick counter, edge detect, rounding and running average.
module pwar_front import pwar_pkg::*; #(
  parameter int unsigned COUNT_WIDTH = COUNT_W_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  logic      pin_level_i,
  input  logic      adv_i,
  output pwar_evt_t evt_o
);

  logic                          prev_level_q;
  logic [COUNT_WIDTH-1:0]        count_q, count_d;
  logic [ACC_BITS-1:0]           acc_q, acc_d;
  logic                          evt_valid_q, evt_valid_d;
  logic                          accept, falling;
  logic [COUNT_WIDTH:0]          cnt_rnd;
  logic [COUNT_WIDTH-1:0]        q_width;
  logic [ACC_BITS+AVG_SHIFT-1:0] acc_scaled;
  logic [ACC_BITS-1:0]           acc_decay;

  // A new item may only arrive once any pending event can move on
  assign in_stall_o = evt_valid_q && !adv_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign falling    = prev_level_q && !pin_level_i;

  // Round the count to the nearest step, wrapping at the counter width
  assign cnt_rnd = {1'b0, count_q} + (COUNT_WIDTH+1)'(ROUND_STEP / 2);
  assign q_width = {cnt_rnd[COUNT_WIDTH-1:ROUND_SHIFT], ROUND_SHIFT'(0)};

  // acc = (acc*(N-1) + N/2) / N + q, modulo 2^ACC_BITS
  assign acc_scaled = (ACC_BITS+AVG_SHIFT)'(acc_q) * (ACC_BITS+AVG_SHIFT)'(AVG_LEN - 1)
                    + (ACC_BITS+AVG_SHIFT)'(AVG_LEN / 2);
  assign acc_decay  = acc_scaled[ACC_BITS+AVG_SHIFT-1:AVG_SHIFT];

  always_comb begin
    count_d     = count_q;
    acc_d       = acc_q;
    evt_valid_d = adv_i ? 1'b0 : evt_valid_q;
    if (accept) begin
      if (pin_level_i) begin
        count_d = count_q + COUNT_WIDTH'(1);
      end
      if (falling) begin
        count_d     = '0;
        acc_d       = acc_decay + ACC_BITS'(q_width);
        evt_valid_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_level_q <= 1'b0;
      count_q      <= '0;
      acc_q        <= '0;
      evt_valid_q  <= 1'b0;
    end else begin
      if (accept) begin
        prev_level_q <= pin_level_i;
      end
      count_q     <= count_d;
      acc_q       <= acc_d;
      evt_valid_q <= evt_valid_d;
    end
  end

  assign evt_o.valid = evt_valid_q;
  assign evt_o.acc   = acc_q;

endmodule

// ===== rtl/pwar_back.sv =====
// Result stage: rounded average, change flag, distance and output register.
module pwar_back import pwar_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  pwar_evt_t                evt_i,
  output logic                     adv_o,
  input  logic [WIDTH_US-1:0]      limit_i,
  input  logic [WIDTH_US-1:0]      offset_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [WIDTH_US-1:0]      avg_width_us_o,
  output logic                     avg_changed_o,
  output logic signed [DIST_W-1:0] distance_mm_o,
  output logic                     distance_valid_o
);

  localparam int unsigned DiffW = WIDTH_US + 2;
  localparam int unsigned ProdW = DiffW + 2;

  logic                     out_valid_q;
  logic [WIDTH_US-1:0]      avg_q, last_avg_q;
  logic                     changed_q, dvalid_q;
  logic signed [DIST_W-1:0] dist_q;

  logic [ACC_BITS:0]        acc_rnd;
  logic [WIDTH_US-1:0]      avg;
  logic                     dvalid;
  logic signed [DiffW-1:0]  diff;
  logic signed [ProdW-1:0]  prod, quot;
  logic signed [DIST_W-1:0] dist_d;

  // Event moves into the output register when it is free or draining
  assign adv_o = evt_i.valid && (!out_valid_q || !out_stall_i);

  // Rounded average, truncated to the field width
  assign acc_rnd = {1'b0, evt_i.acc} + (ACC_BITS+1)'(AVG_LEN / 2);
  assign avg     = acc_rnd[AVG_SHIFT +: WIDTH_US];
  assign dvalid  = avg < limit_i;

  // (d*3 + 2) / 4 with truncation toward zero
  assign diff = $signed({2'b00, avg}) - $signed({2'b00, offset_i});
  assign prod = ProdW'(diff) * $signed(ProdW'(DIST_MUL)) + $signed(ProdW'(DIST_DIV / 2));
  assign quot = prod[ProdW-1] ? ((prod + $signed(ProdW'(DIST_DIV - 1))) >>> DIST_SHIFT)
                              : (prod >>> DIST_SHIFT);
  assign dist_d = dvalid ? quot[DIST_W-1:0] : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      last_avg_q  <= LAST_AVG_RST;
    end else begin
      if (adv_o) begin
        out_valid_q <= 1'b1;
        last_avg_q  <= avg;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload register, loaded with each new result
  always_ff @(posedge clk_i) begin
    if (adv_o) begin
      avg_q     <= avg;
      changed_q <= (avg != last_avg_q);
      dist_q    <= dist_d;
      dvalid_q  <= dvalid;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign avg_width_us_o   = avg_q;
  assign avg_changed_o    = changed_q;
  assign distance_mm_o    = dist_q;
  assign distance_valid_o = dvalid_q;

endmodule

// ===== rtl/pulse_width_average_ranger.sv =====
// Top level of the pulse-width average ranger: config registers and stages.
//
// Channel   Direction  Handshake                 Payload
// in        input      in_valid_i / in_stall_o   pin_level_i
// out       output     out_valid_o / out_stall_i avg_width_us_o, avg_changed_o,
//                                                distance_mm_o, distance_valid_o
// cfg       input      cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// One tick is taken every cycle while in_valid_i is high and in_stall_o is low.
// A falling edge updates the average in the input stage, and its result passes
// to the output register. Reset clears counter, average and handshake state;
// limits reload defaults. With the output stalled, one further edge may wait in
// the input stage; input stalls only while that pending event cannot move on.
module pulse_width_average_ranger import pwar_pkg::*; #(
  parameter int unsigned COUNT_WIDTH = COUNT_W_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic                     pin_level_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [WIDTH_US-1:0]      avg_width_us_o,
  output logic                     avg_changed_o,
  output logic signed [DIST_W-1:0] distance_mm_o,
  output logic                     distance_valid_o,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [WIDTH_US-1:0]      cfg_data_i
);

  logic [WIDTH_US-1:0] limit_q, offset_q;
  pwar_evt_t           evt;
  logic                adv;

  // Configuration writes are always taken
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q  <= LIMIT_RST;
      offset_q <= OFFSET_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_NO_TARGET_LIMIT: limit_q  <= cfg_data_i;
        CFG_ZERO_OFFSET:     offset_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  pwar_front #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .pin_level_i(pin_level_i),
    .adv_i      (adv),
    .evt_o      (evt)
  );

  pwar_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .evt_i           (evt),
    .adv_o           (adv),
    .limit_i         (limit_q),
    .offset_i        (offset_q),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .avg_width_us_o  (avg_width_us_o),
    .avg_changed_o   (avg_changed_o),
    .distance_mm_o   (distance_mm_o),
    .distance_valid_o(distance_valid_o)
  );

endmodule
